[rtl/rpts_pkg.sv]
// rpts_pkg: request and result types, character codes and divider constants
// for the pulse timing statistics unit; no dependencies
package rpts_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_request;

    typedef struct packed {
        logic [23:0] high_count;
        logic [23:0] low_count;
        logic [47:0] total_us;
        logic        any_pulse;
        logic [30:0] min_pulse_us;
        logic [19:0] symbol_rate_hz;
        logic [18:0] manchester_bps;
        logic [18:0] pwm_bps;
        logic [17:0] ppm_bps;
    } t_result;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam int QUOT_BITS = 20;
    localparam int STEP_BITS = 5;
    localparam logic [QUOT_BITS-1:0] RATE_NUM = 20'd1000000;

    // rate / 3 as (rate * ceil(2^21 / 3)) >> 21, exact for any 20-bit rate
    localparam logic [QUOT_BITS-1:0] THIRD_RECIP = 20'd699051;
    localparam int THIRD_SHIFT = 21;

endpackage

[rtl/raw_pulse_timing_statistics_unit.sv]
// raw_pulse_timing_statistics_unit: character parser, pulse statistics and a
// restoring divider for the symbol rate; depends on rpts_pkg
//
// channel  dir  handshake                   payload
// in       in   i_in_valid / o_in_ready     i_in_req  (rpts_pkg::t_request)
// out      out  o_out_valid / i_out_ready   o_out_res (rpts_pkg::t_result)
//
// a character that is not marked last is taken and ready stays high
// after a last character the input closes: one restoring divider does
// 1000000 / shortest pulse, one quotient bit a cycle; rate / 3 is a reciprocal multiply
// the result sits in an output register; characters are taken while it waits
// a result that finds the output register still full stalls the block
// synchronous active-low reset clears all statistics and the output valid flag
module raw_pulse_timing_statistics_unit #(
    parameter int COUNT_BITS    = 24,
    parameter int SUM_BITS      = 48,
    parameter int DURATION_BITS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rpts_pkg::t_request i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rpts_pkg::t_result  o_out_res
);
    import rpts_pkg::*;

    localparam int DB = DURATION_BITS;
    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_DIV_RATE  = 2'd1;
    localparam logic [1:0] S_FINISH    = 2'd2;
    localparam logic [DB-1:0] DUR_MAX = {DB{1'b1}};

    logic [1:0]            r_state, n_state;
    logic [DB-1:0]         r_cur, n_cur;
    logic                  r_neg, n_neg;
    logic [COUNT_BITS-1:0] r_high, n_high, r_low, n_low;
    logic [DB-1:0]         r_sh_high, n_sh_high, r_sh_low, n_sh_low;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [QUOT_BITS-1:0]  r_quo, n_quo, r_rate, n_rate;
    logic [DB:0]           r_rem, n_rem;
    logic [STEP_BITS-1:0]  r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    logic                  in_acc, is_digit, is_minus, do_close, any_hi, any_lo, any_p;
    logic [3:0]            digit;
    logic [DB+3:0]         acc_wide, cur_ext;
    logic [DB-1:0]         acc_val, close_val, minp, divisor;
    logic [SUM_BITS:0]     sum_wide;
    logic [DB:0]           rem_sh;
    logic                  ge, last_step, out_free;
    logic [63:0]           ext_high, ext_low, ext_sum, ext_min;
    logic [2*QUOT_BITS-1:0] third_prod;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        is_digit = i_in_req.char_code inside {[CH_ZERO:CH_NINE]};
        is_minus = (i_in_req.char_code == CH_MINUS);
        digit    = 4'(i_in_req.char_code - CH_ZERO);
        cur_ext  = (DB+4)'(r_cur);
        acc_wide = (cur_ext << 3) + (cur_ext << 1) + (DB+4)'(digit);
        acc_val  = (acc_wide > (DB+4)'(DUR_MAX)) ? DUR_MAX : acc_wide[DB-1:0];
        close_val = is_digit ? acc_val : r_cur;
        do_close  = !is_digit || i_in_req.last;
        sum_wide  = {1'b0, r_sum} + (SUM_BITS+1)'(close_val);
    end

    always_comb begin
        any_hi = |r_high;
        any_lo = |r_low;
        any_p  = any_hi || any_lo;
        if (any_hi && any_lo) begin
            minp = (r_sh_high < r_sh_low) ? r_sh_high : r_sh_low;
        end else if (any_hi) begin
            minp = r_sh_high;
        end else if (any_lo) begin
            minp = r_sh_low;
        end else begin
            minp = '0;
        end
        divisor   = minp;
        rem_sh    = {r_rem[DB-1:0], r_quo[QUOT_BITS-1]};
        ge        = (rem_sh >= {1'b0, divisor});
        last_step = (r_step == STEP_BITS'(QUOT_BITS - 1));
        ext_high  = 64'(r_high);
        ext_low   = 64'(r_low);
        ext_sum   = 64'(r_sum);
        ext_min   = 64'(minp);
        third_prod = (2*QUOT_BITS)'(r_rate) * (2*QUOT_BITS)'(THIRD_RECIP);
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_neg       = r_neg;
        n_high      = r_high;
        n_low       = r_low;
        n_sh_high   = r_sh_high;
        n_sh_low    = r_sh_low;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_rate      = r_rate;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur = do_close ? '0 : acc_val;
                    n_neg = is_minus ? 1'b1 : (is_digit ? r_neg : 1'b0);
                    if (do_close && close_val != '0) begin
                        if (r_neg) begin
                            if (!(&r_low)) n_low = r_low + COUNT_BITS'(1);
                            if (close_val < r_sh_low) n_sh_low = close_val;
                        end else begin
                            if (!(&r_high)) n_high = r_high + COUNT_BITS'(1);
                            if (close_val < r_sh_high) n_sh_high = close_val;
                        end
                        n_sum = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
                    end
                    if (i_in_req.last) begin
                        n_state = S_DIV_RATE;
                        n_quo   = RATE_NUM;
                        n_rem   = '0;
                        n_step  = '0;
                    end
                end
            end
            S_DIV_RATE: begin
                n_rem  = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
                n_quo  = {r_quo[QUOT_BITS-2:0], ge};
                n_step = r_step + STEP_BITS'(1);
                if (last_step) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_rate  = any_p ? n_quo : '0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.high_count     = ext_high[23:0];
                    n_out.low_count      = ext_low[23:0];
                    n_out.total_us       = ext_sum[47:0];
                    n_out.any_pulse      = any_p;
                    n_out.min_pulse_us   = ext_min[30:0];
                    n_out.symbol_rate_hz = r_rate;
                    n_out.manchester_bps = r_rate[QUOT_BITS-1:1];
                    n_out.pwm_bps        = third_prod[2*QUOT_BITS-1:THIRD_SHIFT];
                    n_out.ppm_bps        = r_rate[QUOT_BITS-1:2];
                    n_cur     = '0;
                    n_neg     = 1'b0;
                    n_high    = '0;
                    n_low     = '0;
                    n_sh_high = DUR_MAX;
                    n_sh_low  = DUR_MAX;
                    n_sum     = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_neg       <= 1'b0;
            r_high      <= '0;
            r_low       <= '0;
            r_sh_high   <= DUR_MAX;
            r_sh_low    <= DUR_MAX;
            r_sum       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_neg       <= n_neg;
            r_high      <= n_high;
            r_low       <= n_low;
            r_sh_high   <= n_sh_high;
            r_sh_low    <= n_sh_low;
            r_sum       <= n_sum;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rate <= n_rate;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // a last request starts the divider and closes the input
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_req.last |=> !o_in_ready)
        else $error("input still open after last request");

    // restoring divider keeps its remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV_RATE && divisor != '0
            |-> r_rem < {1'b0, divisor})
        else $error("divider remainder out of range");

    // no pulse means no shortest pulse and no rate
    a_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.any_pulse
            |-> o_out_res.symbol_rate_hz == '0 && o_out_res.min_pulse_us == '0)
        else $error("rate reported without any pulse");

    // a new result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH && r_out_valid && !i_out_ready |=> r_state == S_FINISH)
        else $error("result left the finish state while output was full");

endmodule
